// ----- rtl/ups_pkg.sv -----
// ----------------------------------------------------------------------------
// ups_pkg
// Shared types, constants and register codes for the ultrasonic presence
// scanner.
// ----------------------------------------------------------------------------
package ups_pkg;

  localparam int unsigned NUM_SENSORS_DEF = 4;

  localparam int unsigned IN_W   = 40;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 32;

  localparam logic CMD_ECHO = 1'b0;
  localparam logic CMD_FIRE = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_CLOSE    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FAR      = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_DEBOUNCE = 2'd2;

  localparam logic [15:0] CLOSE_RST    = 16'd18;
  localparam logic [15:0] FAR_RST      = 16'd22;
  localparam logic [31:0] DEBOUNCE_RST = 32'd3000;
  localparam logic [15:0] DIST_RST     = 16'd100;

  // distance = elapsed * 50 / 29, saturated to 16 bits
  localparam int unsigned DIV_SHIFT = 22;
  localparam int unsigned DIV_MULT  = (50 * (32'd1 << DIV_SHIFT) + 28) / 29;
  localparam int unsigned MULT_W    = 23;
  localparam int unsigned PROD_W    = 16 + MULT_W;
  // smallest elapsed count whose distance exceeds 16 bits
  localparam logic [31:0] SAT_LIMIT = 32'((65536 * 29 + 49) / 50);

  localparam int unsigned Q_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_MARK,
    KIND_RANGE,
    KIND_FIRE
  } ups_kind_t;

  typedef struct packed {
    ups_kind_t   kind;
    logic [1:0]  sensor;
    logic [15:0] elapsed;
    logic        sat;
    logic [31:0] now;
  } ups_op_t;

endpackage

// ----- rtl/ups_front.sv -----
// ----------------------------------------------------------------------------
// ups_front
// Accepts input words, tracks echo edge pairs and classifies each word into
// an operation for the back end.
// ----------------------------------------------------------------------------
module ups_front #(
  parameter int unsigned NUM_SENSORS = ups_pkg::NUM_SENSORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [0:0]                 in_tuser,  // [0] command
  input  logic [ups_pkg::IN_W-1:0]   in_tdata,  // [1:0] sensor_index, [33:2] now
  output logic                       q_push,
  output ups_pkg::ups_op_t           q_op,
  input  logic                       q_full
);
  import ups_pkg::*;

  localparam int unsigned SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int unsigned XW = SW + 2;

  logic [31:0]   rise_time_r [NUM_SENSORS];
  logic          rise_pend_r [NUM_SENSORS];

  logic          accept;
  logic          cmd;
  logic [1:0]    sensor;
  logic [31:0]   now;
  logic [XW-1:0] idx_x;
  logic [SW-1:0] idx;
  logic          in_range;
  logic          pend;
  logic [31:0]   diff;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tuser[0];
  assign sensor    = in_tdata[1:0];
  assign now       = in_tdata[33:2];
  assign idx_x     = XW'(sensor);
  assign in_range  = idx_x < XW'(NUM_SENSORS);
  assign idx       = idx_x[SW-1:0];
  assign pend      = in_range && rise_pend_r[idx];
  assign diff      = now - rise_time_r[idx];

  always_comb begin
    q_op.sensor  = sensor;
    q_op.elapsed = diff[15:0];
    q_op.sat     = diff >= SAT_LIMIT;
    q_op.now     = now;
    if (cmd == CMD_FIRE) begin
      q_op.kind = KIND_FIRE;
    end else if (pend) begin
      q_op.kind = KIND_RANGE;
    end else begin
      q_op.kind = KIND_MARK;
    end
  end

  assign q_push = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        rise_pend_r[i] <= 1'b0;
      end
    end else if (accept && cmd == CMD_ECHO && in_range) begin
      rise_pend_r[idx] <= !rise_pend_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_ECHO && in_range && !rise_pend_r[idx]) begin
      rise_time_r[idx] <= now;
    end
  end

endmodule

// ----- rtl/ups_queue.sv -----
// ----------------------------------------------------------------------------
// ups_queue
// Short first-in first-out queue of operations between front and back end.
// ----------------------------------------------------------------------------
module ups_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ups_pkg::ups_op_t push_op,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output ups_pkg::ups_op_t head_op
);
  import ups_pkg::*;

  localparam int unsigned PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  ups_op_t       mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign full    = count_r == CW'(Q_DEPTH);
  assign valid   = count_r != '0;
  assign head_op = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/ups_back.sv -----
// ----------------------------------------------------------------------------
// ups_back
// Executes queued operations: distance conversion, presence hysteresis,
// round-robin trigger, configuration registers and the output register.
// ----------------------------------------------------------------------------
module ups_back #(
  parameter int unsigned NUM_SENSORS = ups_pkg::NUM_SENSORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ups_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ups_pkg::CFG_DW-1:0] cfg_data,
  input  logic                       q_valid,
  input  ups_pkg::ups_op_t           q_op,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [0] distance_valid, [2:1] distance_sensor, [18:3] distance_cm,
  // [19] trigger_valid, [21:20] trigger_sensor, [22] arrival_valid,
  // [24:23] arrival_sensor, [28:25] present_mask, [31:29] zero
  output logic [ups_pkg::OUT_W-1:0]  out_tdata
);
  import ups_pkg::*;

  localparam int unsigned SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  logic [15:0]       close_r;
  logic [15:0]       far_r;
  logic [31:0]       debounce_r;

  logic [15:0]       dist_r    [NUM_SENSORS];
  logic              present_r [NUM_SENSORS];
  logic [31:0]       ptime_r   [NUM_SENSORS];
  logic [SW-1:0]     active_r;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;

  logic [PROD_W-1:0] prod;
  logic [15:0]       dist_cm;
  logic [SW-1:0]     sidx;
  logic [SW-1:0]     prev;
  logic [SW-1:0]     active_nxt;
  logic              near;
  logic              stale;
  logic              set_present;
  logic              clr_present;
  logic              stamp;
  logic [NUM_SENSORS-1:0] present_nxt;
  logic [3:0]        mask;
  logic [OUT_W-1:0]  out_data_nxt;

  assign cfg_ready  = 1'b1;
  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign prod    = PROD_W'(q_op.elapsed) * PROD_W'(DIV_MULT);
  assign dist_cm = q_op.sat ? 16'hFFFF : prod[DIV_SHIFT +: 16];
  assign sidx    = SW'(q_op.sensor);

  assign prev       = (active_r == '0) ? SW'(NUM_SENSORS - 1) : active_r - 1'b1;
  assign active_nxt = (active_r == SW'(NUM_SENSORS - 1)) ? '0 : active_r + 1'b1;
  assign near       = dist_r[prev] < close_r;
  assign stale      = (q_op.now - ptime_r[prev]) > debounce_r;

  always_comb begin
    set_present = 1'b0;
    clr_present = 1'b0;
    stamp       = 1'b0;
    if (q_op.kind == KIND_FIRE) begin
      if (near) begin
        set_present = !present_r[prev];
        stamp       = 1'b1;
      end else if (present_r[prev] && dist_r[prev] >= far_r && stale) begin
        clr_present = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      present_nxt[i] = present_r[i];
    end
    if (set_present) begin
      present_nxt[prev] = 1'b1;
    end else if (clr_present) begin
      present_nxt[prev] = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      mask[i] = (i < NUM_SENSORS) ? present_nxt[i % NUM_SENSORS] : 1'b0;
    end
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[28:25] = mask;
    unique case (q_op.kind)
      KIND_RANGE: begin
        out_data_nxt[0]    = 1'b1;
        out_data_nxt[2:1]  = q_op.sensor;
        out_data_nxt[18:3] = dist_cm;
      end
      KIND_FIRE: begin
        out_data_nxt[19]    = 1'b1;
        out_data_nxt[21:20] = 2'(active_r);
        out_data_nxt[22]    = set_present;
        out_data_nxt[24:23] = set_present ? 2'(prev) : 2'd0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_r    <= CLOSE_RST;
      far_r      <= FAR_RST;
      debounce_r <= DEBOUNCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CLOSE:    close_r    <= cfg_data[15:0];
        CFG_FAR:      far_r      <= cfg_data[15:0];
        CFG_DEBOUNCE: debounce_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        dist_r[i]    <= DIST_RST;
        present_r[i] <= 1'b0;
      end
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop && q_op.kind == KIND_RANGE) begin
        dist_r[sidx] <= dist_cm;
      end
      if (q_pop && q_op.kind == KIND_FIRE) begin
        active_r <= active_nxt;
        for (int i = 0; i < NUM_SENSORS; i++) begin
          present_r[i] <= present_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
    if (q_pop && stamp) begin
      ptime_r[prev] <= q_op.now;
    end
  end

endmodule

// ----- rtl/ultrasonic_presence_scanner.sv -----
// ----------------------------------------------------------------------------
// ultrasonic_presence_scanner
// Round-robin ultrasonic ranging with presence detection and hysteresis.
//
//   channel  dir  ports                          word
//   in       in   in_tvalid/tready/tuser/tdata   command, sensor_index, now
//   out      out  out_tvalid/tready/tdata        distance, trigger, arrival, mask
//   cfg      in   cfg_valid/ready/index/data     register write
//
// One word per cycle sustained while the output is not stalled; the front
// classifies each word into the queue, then back-end execution writes the
// output register, where a 16x23 multiply does the distance scaling.
// Synchronous active-low reset; no clearing pass. The two-entry queue lets
// the front keep accepting while the output stalls, and the front stalls
// only when the queue is full.
// ----------------------------------------------------------------------------
module ultrasonic_presence_scanner #(
  parameter int unsigned NUM_SENSORS = ups_pkg::NUM_SENSORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [0:0]                 in_tuser,   // [0] command
  input  logic [ups_pkg::IN_W-1:0]   in_tdata,   // [1:0] sensor_index, [33:2] now
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [0] distance_valid, [2:1] distance_sensor, [18:3] distance_cm,
  // [19] trigger_valid, [21:20] trigger_sensor, [22] arrival_valid,
  // [24:23] arrival_sensor, [28:25] present_mask
  output logic [ups_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ups_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ups_pkg::CFG_DW-1:0] cfg_data
);
  import ups_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  ups_op_t push_op;
  ups_op_t head_op;

  ups_front #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_push    (q_push),
    .q_op      (push_op),
    .q_full    (q_full)
  );

  ups_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head_op (head_op)
  );

  ups_back #(
    .NUM_SENSORS(NUM_SENSORS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_op       (head_op),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
